// ===== design/fdr_pkg.sv =====
// ----------------------------------------------------------------------------
// fdr_pkg
// shared types and constants for the fan duty ramp and tach average core
// ----------------------------------------------------------------------------
`default_nettype none

package fdr_pkg;

    // input item kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_RAMP   = 2'd1;
    localparam logic [1:0] KIND_PULSE  = 2'd2;
    localparam logic [1:0] KIND_SAMPLE = 2'd3;

    // report kinds
    localparam logic [1:0] REP_TARGET  = 2'd0;
    localparam logic [1:0] REP_RPM     = 2'd1;
    localparam logic [1:0] REP_COMPARE = 2'd2;

    // configuration register indexes
    localparam logic CFG_RPM_PER_PULSE = 1'b0;
    localparam logic CFG_RAMP_INTERVAL = 1'b1;

    // decoded operations
    localparam logic [2:0] OP_LETTER = 3'd0;
    localparam logic [2:0] OP_DIGIT  = 3'd1;
    localparam logic [2:0] OP_EOL    = 3'd2;
    localparam logic [2:0] OP_RAMP   = 3'd3;
    localparam logic [2:0] OP_PULSE  = 3'd4;
    localparam logic [2:0] OP_SAMPLE = 3'd5;

    // characters
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_K = 8'h4B;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_K = 8'h6B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;

    localparam logic [1:0] MAX_DIGITS  = 2'd3;
    localparam logic [6:0] DUTY_MAX    = 7'd100;
    localparam logic [9:0] TYPED_LIMIT = 10'd100;

    // percent * 255 / 100 as a multiply by a scaled reciprocal
    localparam logic [20:0] CMP_MULT  = 21'd1336965;
    localparam int          CMP_SHIFT = 19;

    localparam logic [5:0] RPM_PER_PULSE_RESET = 6'd60;
    localparam logic [7:0] RAMP_INTERVAL_RESET = 8'd20;

    localparam int QPTRW = 1;
    localparam logic [QPTRW:0] QUEUE_DEPTH = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] val;
    } t_op;

endpackage

`default_nettype wire

// ===== design/fdr_front.sv =====
// ----------------------------------------------------------------------------
// fdr_front
// classifies items into operations; bytes not in A-K, a-k, 0-9, CR/LF dropped
// ----------------------------------------------------------------------------
`default_nettype none

module fdr_front (
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_rx_byte,
    output fdr_pkg::t_op    o_op,
    output logic            o_keep
);

    logic       is_upper;
    logic       is_lower;
    logic       is_digit;
    logic       is_eol;
    logic [7:0] letter_idx;
    logic [7:0] digit_val;

    assign is_upper = (i_rx_byte >= fdr_pkg::CH_UPPER_A) && (i_rx_byte <= fdr_pkg::CH_UPPER_K);
    assign is_lower = (i_rx_byte >= fdr_pkg::CH_LOWER_A) && (i_rx_byte <= fdr_pkg::CH_LOWER_K);
    assign is_digit = (i_rx_byte >= fdr_pkg::CH_ZERO) && (i_rx_byte <= fdr_pkg::CH_NINE);
    assign is_eol   = (i_rx_byte == fdr_pkg::CH_CR) || (i_rx_byte == fdr_pkg::CH_LF);

    assign letter_idx = is_lower ? (i_rx_byte - fdr_pkg::CH_LOWER_A)
                                 : (i_rx_byte - fdr_pkg::CH_UPPER_A);
    assign digit_val  = i_rx_byte - fdr_pkg::CH_ZERO;

    always_comb begin
        o_op   = '0;
        o_keep = 1'b1;
        case (i_kind)
            fdr_pkg::KIND_BYTE: begin
                if (is_upper || is_lower) begin
                    o_op.op  = fdr_pkg::OP_LETTER;
                    o_op.val = (7'(letter_idx[3:0]) << 3) + (7'(letter_idx[3:0]) << 1);
                end else if (is_digit) begin
                    o_op.op  = fdr_pkg::OP_DIGIT;
                    o_op.val = 7'(digit_val[3:0]);
                end else if (is_eol) begin
                    o_op.op  = fdr_pkg::OP_EOL;
                end else begin
                    o_keep   = 1'b0;
                end
            end
            fdr_pkg::KIND_RAMP:  o_op.op = fdr_pkg::OP_RAMP;
            fdr_pkg::KIND_PULSE: o_op.op = fdr_pkg::OP_PULSE;
            default:             o_op.op = fdr_pkg::OP_SAMPLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/fdr_queue.sv =====
// ----------------------------------------------------------------------------
// fdr_queue
// two-entry queue of decoded operations between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module fdr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire fdr_pkg::t_op  i_op,
    output logic               o_full,
    output logic               o_valid,
    output fdr_pkg::t_op       o_op,
    input  wire logic          i_pop
);

    fdr_pkg::t_op                r_mem [2**fdr_pkg::QPTRW];
    logic [fdr_pkg::QPTRW-1:0]   r_wr_ptr;
    logic [fdr_pkg::QPTRW-1:0]   r_rd_ptr;
    logic [fdr_pkg::QPTRW:0]     r_count;

    assign o_full  = (r_count == fdr_pkg::QUEUE_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/fdr_back.sv =====
// ----------------------------------------------------------------------------
// fdr_back
// executes operations against duty, typed number, tach and history state,
// and holds the result item in an output register
// ----------------------------------------------------------------------------
`default_nettype none

module fdr_back #(
    parameter int AVERAGE_WINDOW = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire fdr_pkg::t_op i_op,
    output logic             o_pop,
    input  wire logic [5:0]  i_rpm_per_pulse,
    input  wire logic [7:0]  i_ramp_interval,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_report_kind,
    output logic [6:0]       o_target_percent,
    output logic [15:0]      o_average_rpm,
    output logic [7:0]       o_compare_value
);

    localparam int LOGW   = $clog2(AVERAGE_WINDOW);
    localparam int SUMW   = 16 + LOGW;
    localparam int SLOTW  = (AVERAGE_WINDOW > 1) ? $clog2(AVERAGE_WINDOW) : 1;
    localparam int RSHIFT = SUMW + LOGW;
    localparam int RECIP  = ((1 << RSHIFT) + AVERAGE_WINDOW - 1) / AVERAGE_WINDOW;
    localparam logic [SUMW:0]    RECIP_V  = (SUMW + 1)'(RECIP);
    localparam logic [SLOTW-1:0] SLOT_END = SLOTW'(AVERAGE_WINDOW - 1);

    logic [6:0]       r_goal,    n_goal;
    logic [6:0]       r_present, n_present;
    logic [9:0]       r_typed,   n_typed;
    logic [1:0]       r_digits,  n_digits;
    logic [7:0]       r_ticks,   n_ticks;
    logic [15:0]      r_tally,   n_tally;
    logic [SLOTW-1:0] r_slot,    n_slot;
    logic [SUMW-1:0]  r_sum,     n_sum;
    logic [15:0]      r_hist [AVERAGE_WINDOW];

    logic             r_out_valid;
    logic [1:0]       r_out_kind;
    logic [6:0]       r_out_pct;
    logic [SUMW-1:0]  r_out_sum;

    logic             out_free;
    logic             emit;
    logic [1:0]       rep_kind;
    logic [6:0]       rep_pct;
    logic             hist_we;
    logic [7:0]       tick;
    logic [21:0]      rpm_prod;
    logic [15:0]      rpm;
    logic [13:0]      typed_acc;
    logic [27:0]      cmp_prod;
    logic [2*SUMW:0]  avg_prod;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = i_q_valid && out_free;

    assign tick      = r_ticks + 8'd1;
    assign rpm_prod  = 22'(r_tally) * 22'(i_rpm_per_pulse);
    assign rpm       = rpm_prod[15:0];
    assign typed_acc = (14'(r_typed) << 3) + (14'(r_typed) << 1) + 14'(i_op.val);

    always_comb begin
        n_goal    = r_goal;
        n_present = r_present;
        n_typed   = r_typed;
        n_digits  = r_digits;
        n_ticks   = r_ticks;
        n_tally   = r_tally;
        n_slot    = r_slot;
        n_sum     = r_sum;
        emit      = 1'b0;
        rep_kind  = fdr_pkg::REP_TARGET;
        rep_pct   = '0;
        hist_we   = 1'b0;
        case (i_op.op)
            fdr_pkg::OP_LETTER: begin
                n_goal  = i_op.val;
                emit    = 1'b1;
                rep_pct = i_op.val;
            end
            fdr_pkg::OP_DIGIT: begin
                if (r_digits < fdr_pkg::MAX_DIGITS) begin
                    n_typed  = typed_acc[9:0];
                    n_digits = r_digits + 2'd1;
                end
            end
            fdr_pkg::OP_EOL: begin
                if (r_digits != 2'd0) begin
                    n_goal   = (r_typed > fdr_pkg::TYPED_LIMIT) ? fdr_pkg::DUTY_MAX
                                                                : r_typed[6:0];
                    n_typed  = '0;
                    n_digits = '0;
                    emit     = 1'b1;
                    rep_pct  = n_goal;
                end
            end
            fdr_pkg::OP_RAMP: begin
                if (tick < i_ramp_interval) begin
                    n_ticks = tick;
                end else begin
                    n_ticks = '0;
                    if (r_present < r_goal) begin
                        n_present = r_present + 7'd1;
                    end else if (r_present > r_goal) begin
                        n_present = r_present - 7'd1;
                    end
                    emit     = 1'b1;
                    rep_kind = fdr_pkg::REP_COMPARE;
                    rep_pct  = n_present;
                end
            end
            fdr_pkg::OP_PULSE: begin
                n_tally = r_tally + 16'd1;
            end
            fdr_pkg::OP_SAMPLE: begin
                n_tally  = '0;
                hist_we  = 1'b1;
                n_sum    = r_sum - SUMW'(r_hist[r_slot]) + SUMW'(rpm);
                n_slot   = (r_slot == SLOT_END) ? '0 : r_slot + 1'b1;
                emit     = 1'b1;
                rep_kind = fdr_pkg::REP_RPM;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal      <= '0;
            r_present   <= '0;
            r_typed     <= '0;
            r_digits    <= '0;
            r_ticks     <= '0;
            r_tally     <= '0;
            r_slot      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < AVERAGE_WINDOW; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_goal    <= n_goal;
                r_present <= n_present;
                r_typed   <= n_typed;
                r_digits  <= n_digits;
                r_ticks   <= n_ticks;
                r_tally   <= n_tally;
                r_slot    <= n_slot;
                r_sum     <= n_sum;
                if (hist_we) begin
                    r_hist[r_slot] <= rpm;
                end
            end
            if (out_free) begin
                r_out_valid <= o_pop && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_kind <= rep_kind;
            r_out_pct  <= rep_pct;
            r_out_sum  <= n_sum;
        end
    end

    // output conversion off the result register
    assign cmp_prod = 28'(r_out_pct) * 28'(fdr_pkg::CMP_MULT);
    assign avg_prod = (2 * SUMW + 1)'(r_out_sum) * (2 * SUMW + 1)'(RECIP_V);

    assign o_valid          = r_out_valid;
    assign o_report_kind    = r_out_kind;
    assign o_target_percent = (r_out_kind == fdr_pkg::REP_TARGET) ? r_out_pct : '0;
    assign o_compare_value  = (r_out_kind == fdr_pkg::REP_COMPARE)
                              ? cmp_prod[fdr_pkg::CMP_SHIFT +: 8] : '0;
    assign o_average_rpm    = (r_out_kind == fdr_pkg::REP_RPM) ? avg_prod[RSHIFT +: 16] : '0;

endmodule

`default_nettype wire

// ===== design/fan_duty_ramp_and_tach_average_core.sv =====
// ----------------------------------------------------------------------------
// fan_duty_ramp_and_tach_average_core
// fan duty slew limiter with command parser and tachometer moving average
// ----------------------------------------------------------------------------
// a result item is held in the queue and then in the output register before it is presented
// throughput: one item per cycle while the output is not stalled
// a two-entry queue absorbs output stalls before input stall rises
// reset clears all duty, parser, tach and history state; config to 60 and 20
`default_nettype none

module fan_duty_ramp_and_tach_average_core #(
    parameter int AVERAGE_WINDOW = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_report_kind,
    output logic [6:0]       o_target_percent,
    output logic [15:0]      o_average_rpm,
    output logic [7:0]       o_compare_value,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic [5:0]    r_rpm_per_pulse;
    logic [7:0]    r_ramp_interval;
    fdr_pkg::t_op  front_op;
    fdr_pkg::t_op  queue_op;
    logic          front_keep;
    logic          queue_full;
    logic          queue_valid;
    logic          queue_pop;
    logic          push;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = queue_full;
    assign push        = i_valid && !queue_full && front_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpm_per_pulse <= fdr_pkg::RPM_PER_PULSE_RESET;
            r_ramp_interval <= fdr_pkg::RAMP_INTERVAL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fdr_pkg::CFG_RPM_PER_PULSE: r_rpm_per_pulse <= i_cfg_data[5:0];
                fdr_pkg::CFG_RAMP_INTERVAL: r_ramp_interval <= i_cfg_data;
                default:                    r_ramp_interval <= r_ramp_interval;
            endcase
        end
    end

    fdr_front u_front (
        .i_kind    (i_kind),
        .i_rx_byte (i_rx_byte),
        .o_op      (front_op),
        .o_keep    (front_keep)
    );

    fdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_op    (queue_op),
        .i_pop   (queue_pop)
    );

    fdr_back #(
        .AVERAGE_WINDOW (AVERAGE_WINDOW)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (queue_valid),
        .i_op             (queue_op),
        .o_pop            (queue_pop),
        .i_rpm_per_pulse  (r_rpm_per_pulse),
        .i_ramp_interval  (r_ramp_interval),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_report_kind    (o_report_kind),
        .o_target_percent (o_target_percent),
        .o_average_rpm    (o_average_rpm),
        .o_compare_value  (o_compare_value)
    );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for fan_duty_ramp_and_tach_average_core: a directed
// table of command bytes, ramp ticks, tach pulses and sample ticks, then
// random traffic over several register settings under three idling modes,
// every report compared field by field against its typed row or a cycle-free duty/tach model
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fdr_pkg::*;

    localparam int AVG_WINDOW    = 5;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 6;
    localparam int LONG_RUN      = 1100;

    typedef enum logic [1:0] {
        TAG_PRED,
        TAG_NONE,
        TAG_TYPED
    } check_tag_e;

    typedef struct packed {
        logic [1:0]  rkind;
        logic [6:0]  target;
        logic [15:0] avg_rpm;
        logic [7:0]  cmp;
    } report_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        check_tag_e tag;
        report_t    typed;
    } stim_row_t;

    localparam report_t NO_REP = '0;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [1:0]  i_kind      = '0;
    logic [7:0]  i_rx_byte   = '0;
    logic        i_stall     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data  = '0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_report_kind;
    logic [6:0]  o_target_percent;
    logic [15:0] o_average_rpm;
    logic [7:0]  o_compare_value;
    logic        o_cfg_ready;

    check_tag_e  stim_tag   = TAG_PRED;
    report_t     stim_typed = '0;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int mismatch_count  = 0;
    int items_taken     = 0;
    int reports_checked = 0;
    int settings_used   = 0;

    // duty, parser and tach model state
    logic [6:0]  goal_pct;
    logic [6:0]  duty_pct;
    logic [9:0]  digit_value;
    logic [1:0]  digit_count;
    logic [7:0]  tick_count;
    logic [15:0] tach_count;
    logic [15:0] rpm_ring [AVG_WINDOW];
    int          ring_pos;
    logic [5:0]  cfg_rpm_per_pulse;
    logic [7:0]  cfg_ramp_interval;

    report_t pending_reports [$];

    stim_row_t directed_rows [0:28] = '{
        '{KIND_BYTE,   CH_UPPER_A,        TAG_TYPED, '{REP_TARGET, 7'd0, 16'd0, 8'd0}},
        '{KIND_BYTE,   CH_UPPER_K,        TAG_TYPED, '{REP_TARGET, DUTY_MAX, 16'd0, 8'd0}},
        '{KIND_RAMP,   8'h00,             TAG_TYPED, '{REP_COMPARE, 7'd0, 16'd0, 8'd2}},
        '{KIND_BYTE,   CH_LOWER_K,        TAG_TYPED, '{REP_TARGET, DUTY_MAX, 16'd0, 8'd0}},
        '{KIND_BYTE,   CH_LOWER_A,        TAG_TYPED, '{REP_TARGET, 7'd0, 16'd0, 8'd0}},
        '{KIND_RAMP,   8'hFF,             TAG_TYPED, '{REP_COMPARE, 7'd0, 16'd0, 8'd0}},
        '{KIND_BYTE,   CH_CR,             TAG_NONE,  NO_REP},
        '{KIND_BYTE,   CH_ZERO + 8'd2,    TAG_PRED,  NO_REP},
        '{KIND_BYTE,   CH_ZERO + 8'd5,    TAG_PRED,  NO_REP},
        '{KIND_BYTE,   CH_ZERO + 8'd5,    TAG_PRED,  NO_REP},
        '{KIND_BYTE,   CH_NINE,           TAG_NONE,  NO_REP},
        '{KIND_BYTE,   CH_LF,             TAG_TYPED, '{REP_TARGET, DUTY_MAX, 16'd0, 8'd0}},
        '{KIND_BYTE,   CH_ZERO,           TAG_PRED,  NO_REP},
        '{KIND_BYTE,   CH_ZERO,           TAG_PRED,  NO_REP},
        '{KIND_BYTE,   CH_ZERO + 8'd7,    TAG_PRED,  NO_REP},
        '{KIND_BYTE,   CH_CR,             TAG_TYPED, '{REP_TARGET, 7'd7, 16'd0, 8'd0}},
        '{KIND_BYTE,   8'hFF,             TAG_NONE,  NO_REP},
        '{KIND_BYTE,   8'h00,             TAG_NONE,  NO_REP},
        '{KIND_BYTE,   CH_UPPER_A - 8'd1, TAG_NONE,  NO_REP},
        '{KIND_BYTE,   CH_UPPER_K + 8'd1, TAG_NONE,  NO_REP},
        '{KIND_BYTE,   CH_NINE + 8'd1,    TAG_NONE,  NO_REP},
        '{KIND_PULSE,  8'hFF,             TAG_PRED,  NO_REP},
        '{KIND_PULSE,  8'h00,             TAG_PRED,  NO_REP},
        '{KIND_PULSE,  8'hA5,             TAG_PRED,  NO_REP},
        '{KIND_SAMPLE, 8'h5A,             TAG_TYPED, '{REP_RPM, 7'd0, 16'd36, 8'd0}},
        '{KIND_SAMPLE, 8'h00,             TAG_TYPED, '{REP_RPM, 7'd0, 16'd36, 8'd0}},
        '{KIND_RAMP,   8'h3C,             TAG_TYPED, '{REP_COMPARE, 7'd0, 16'd0, 8'd2}},
        '{KIND_BYTE,   CH_LOWER_K + 8'd1, TAG_NONE,  NO_REP},
        '{KIND_BYTE,   CH_ZERO - 8'd1,    TAG_NONE,  NO_REP}
    };

    int phase_rpm      [PHASES] = '{1, 60, 0, 37, 0, 60};
    int phase_interval [PHASES] = '{1, 255, 0, 3, 0, 2};
    int phase_items    [PHASES] = '{100, 80, 80, 80, 80, 80};
    int phase_ramp     [PHASES] = '{30, 75, 30, 30, 30, 30};

    fan_duty_ramp_and_tach_average_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_report_kind    (o_report_kind),
        .o_target_percent (o_target_percent),
        .o_average_rpm    (o_average_rpm),
        .o_compare_value  (o_compare_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    function automatic bit predict_report(input logic [1:0] kind, input logic [7:0] data,
                                          output report_t rep);
        logic [31:0] product;
        logic [31:0] sum;
        rep = '0;
        predict_report = 1'b0;
        case (kind)
            KIND_BYTE: begin
                if ((data >= CH_UPPER_A && data <= CH_UPPER_K) ||
                    (data >= CH_LOWER_A && data <= CH_LOWER_K)) begin
                    goal_pct = 7'((data - ((data >= CH_LOWER_A) ? CH_LOWER_A : CH_UPPER_A)) * 10);
                    rep.rkind = REP_TARGET;
                    rep.target = goal_pct;
                    predict_report = 1'b1;
                end else if (data >= CH_ZERO && data <= CH_NINE) begin
                    if (digit_count < MAX_DIGITS) begin
                        digit_value = 10'(digit_value * 10 + 10'(data - CH_ZERO));
                        digit_count = digit_count + 2'd1;
                    end
                end else if ((data == CH_CR || data == CH_LF) && digit_count != 2'd0) begin
                    goal_pct = (digit_value > TYPED_LIMIT) ? DUTY_MAX : digit_value[6:0];
                    digit_value = '0;
                    digit_count = '0;
                    rep.rkind = REP_TARGET;
                    rep.target = goal_pct;
                    predict_report = 1'b1;
                end
            end
            KIND_RAMP: begin
                tick_count = tick_count + 8'd1;
                if (tick_count >= cfg_ramp_interval) begin
                    tick_count = '0;
                    if (duty_pct < goal_pct) begin
                        duty_pct = duty_pct + 7'd1;
                    end else if (duty_pct > goal_pct) begin
                        duty_pct = duty_pct - 7'd1;
                    end
                    rep.rkind = REP_COMPARE;
                    rep.cmp = 8'((32'(duty_pct) * 255) / DUTY_MAX);
                    predict_report = 1'b1;
                end
            end
            KIND_PULSE: begin
                tach_count = tach_count + 16'd1;
            end
            default: begin
                product = 32'(tach_count) * 32'(cfg_rpm_per_pulse);
                tach_count = '0;
                rpm_ring[ring_pos] = product[15:0];
                ring_pos = (ring_pos + 1) % AVG_WINDOW;
                sum = '0;
                for (int i = 0; i < AVG_WINDOW; i++) begin
                    sum = sum + 32'(rpm_ring[i]);
                end
                rep.rkind = REP_RPM;
                rep.avg_rpm = 16'(sum / AVG_WINDOW);
                predict_report = 1'b1;
            end
        endcase
    endfunction

    // results are checked before the item of the same edge is predicted
    always @(posedge i_clk) begin : scoreboard
        report_t got;
        report_t want;
        report_t pred;
        bit      produced;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_report_kind, o_target_percent, o_average_rpm, o_compare_value};
                if (pending_reports.size() == 0) begin
                    flag_mismatch($sformatf("unexpected report of kind %0d", got.rkind));
                end else begin
                    want = pending_reports.pop_front();
                    reports_checked++;
                    check_field("report_kind", 16'(got.rkind), 16'(want.rkind));
                    check_field("target_percent", 16'(got.target), 16'(want.target));
                    check_field("average_rpm", got.avg_rpm, want.avg_rpm);
                    check_field("compare_value", 16'(got.cmp), 16'(want.cmp));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_RPM_PER_PULSE) begin
                    cfg_rpm_per_pulse = i_cfg_data[5:0];
                end else begin
                    cfg_ramp_interval = i_cfg_data;
                end
            end
            if (i_valid && !o_stall) begin
                produced = predict_report(i_kind, i_rx_byte, pred);
                items_taken++;
                case (stim_tag)
                    TAG_PRED: begin
                        if (produced) begin
                            pending_reports.push_back(pred);
                        end
                    end
                    TAG_TYPED: begin
                        pending_reports.push_back(stim_typed);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
                             input check_tag_e tag, input report_t typed);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_rx_byte  <= data;
        stim_tag   <= tag;
        stim_typed <= typed;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_reports.size() != 0);
    endtask

    task automatic write_register(input logic index, input logic [7:0] data);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int         n;
        int         r;
        int         rpm_set;
        int         interval_set;
        logic [1:0] k;
        logic [7:0] b;
        goal_pct = '0;
        duty_pct = '0;
        digit_value = '0;
        digit_count = '0;
        tick_count = '0;
        tach_count = '0;
        ring_pos = 0;
        for (int i = 0; i < AVG_WINDOW; i++) begin
            rpm_ring[i] = '0;
        end
        cfg_rpm_per_pulse = RPM_PER_PULSE_RESET;
        cfg_ramp_interval = RAMP_INTERVAL_RESET;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_register(CFG_RAMP_INTERVAL, 8'd1);
        settings_used++;
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].kind, directed_rows[i].data,
                      directed_rows[i].tag, directed_rows[i].typed);
        end

        for (int p = 0; p < PHASES; p++) begin
            send_idle_pct = (p < 2) ? 17 : (p < 4) ? 74 : 0;
            recv_idle_pct = (p < 2) ? 74 : (p < 4) ? 17 : 0;
            rpm_set      = (p == 4) ? $urandom_range(1, 60) : phase_rpm[p];
            interval_set = (p == 4) ? $urandom_range(1, 8) : phase_interval[p];
            write_register(CFG_RPM_PER_PULSE, 8'(rpm_set));
            write_register(CFG_RAMP_INTERVAL, 8'(interval_set));
            settings_used++;
            n = 0;
            while (n < phase_items[p]) begin
                if (n == phase_items[p] / 2) begin
                    hold_until_drained();
                end
                if (p == 1 && n == 10) begin
                    // long pulse run so the rpm product overflows 16 bits
                    repeat (LONG_RUN) send_item(KIND_PULSE, 8'($urandom_range(0, 255)),
                                                TAG_PRED, NO_REP);
                    send_item(KIND_SAMPLE, 8'h00, TAG_PRED, NO_REP);
                end else begin
                    r = $urandom_range(0, 99);
                    b = 8'($urandom_range(0, 255));
                    if (r < phase_ramp[p]) begin
                        k = KIND_RAMP;
                    end else begin
                        r = $urandom_range(0, 99);
                        k = (r < 50) ? KIND_BYTE : (r < 85) ? KIND_PULSE : KIND_SAMPLE;
                    end
                    if (k == KIND_BYTE) begin
                        r = $urandom_range(0, 99);
                        if (r < 30) begin
                            b = ((r < 15) ? CH_UPPER_A : CH_LOWER_A) + 8'($urandom_range(0, 10));
                        end else if (r < 70) begin
                            b = CH_ZERO + 8'($urandom_range(0, 9));
                        end else if (r < 85) begin
                            b = r[0] ? CH_CR : CH_LF;
                        end
                    end
                    send_item(k, b, TAG_PRED, NO_REP);
                end
                n++;
            end
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (pending_reports.size() != 0) begin
            flag_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));
        end
        $display("covered %0d items and %0d reports over %0d register settings,",
                 items_taken, reports_checked, settings_used);
        $display("including zero and full-scale multiplier and ramp interval, rpm overflow");
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(64'd50_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/fdr_pkg.sv
design/fdr_front.sv
design/fdr_queue.sv
design/fdr_back.sv
design/fan_duty_ramp_and_tach_average_core.sv
tb/sv/testbench.sv
